// ----- sv/u16u8_pkg.sv -----
// shared types and constants for the utf-16 to utf-8 transcoder
`default_nettype none
package u16u8_pkg;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_FINISHED  = 2'd1,
    ST_INVALID   = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic {
    REG_CHECK_VALIDITY  = 1'b0,
    REG_EXPLICIT_LENGTH = 1'b1
  } reg_index_t;

  localparam int CFG_DATA_W = 1;
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [15:0] NONCHAR_LO = 16'hFDD0;
  localparam logic [15:0] NONCHAR_HI = 16'hFDEF;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    status_t     status;
    logic        last_of_run;
    logic [31:0] bytes_written;
    logic [31:0] units_consumed;
  } out_item_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nb;
    status_t         st;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/utf16_to_utf8_transcoder.sv -----
// utf16_to_utf8_transcoder: utf-16 code units in, utf-8 result beats out
//
// input: an item (code unit and last-unit flag) is taken on a clock edge with push
// high and full low. results: while empty is low the oldest result is on out_item,
// and it is taken on an edge with pop high. the configuration port writes
// check_validity (index 0) or explicit_length (index 1) on any edge with cfg_we.
// the front end classifies and encodes a unit in the cycle it is taken and puts one
// job (up to four bytes plus a status) into a four-entry job queue; the back end
// hands the job out as one result beat per cycle while pop is high. a unit is
// accepted every cycle while the job queue has room, and a result first shows in
// the cycle after its unit. sustained throughput is set by the back end: one result
// beat per cycle while popped, and a unit causes 1 to 4 beats (a held high
// surrogate causes none). when the receiver stops popping, the job queue fills and
// full goes high; nothing is lost. synchronous reset clears both counters, the
// pairing and stop state and the queue, and sets both registers to 1. after an end
// or error, units are still accepted but ignored until reset.
`default_nettype none
module utf16_to_utf8_transcoder import u16u8_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire reg_index_t            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_item_t              in_item,
  input  wire logic                  pop,
  output logic                       empty,
  output out_item_t                  out_item
);

  logic                   acc;
  logic                   f_push;
  job_t                   f_job;
  logic [COUNT_WIDTH-1:0] f_base, f_units;
  logic                   q_empty, q_pop;
  job_t                   h_job;
  logic [COUNT_WIDTH-1:0] h_base, h_units;

  assign acc = push && !full;

  u16u8_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (acc),
    .item      (in_item),
    .job_push  (f_push),
    .job       (f_job),
    .job_base  (f_base),
    .job_units (f_units)
  );

  u16u8_jobq #(.COUNT_WIDTH(COUNT_WIDTH)) u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_job   (f_job),
    .push_base  (f_base),
    .push_units (f_units),
    .full       (full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head_job   (h_job),
    .head_base  (h_base),
    .head_units (h_units)
  );

  u16u8_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (h_job),
    .job_base  (h_base),
    .job_units (h_units),
    .job_done  (q_pop),
    .take      (pop),
    .result    (out_item)
  );

  assign empty = q_empty;

  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.status != ST_DATA)) |-> out_item.last_of_run)
    else $error("status beat not last of its run");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("results pending after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !acc) |=> empty)
    else $error("result appeared without an accepted unit");

endmodule
`default_nettype wire

// ----- sv/u16u8_front.sv -----
// front end: configuration, surrogate pairing, validity checks and byte encoding
`default_nettype none
module u16u8_front import u16u8_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire reg_index_t             cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   accept,
  input  wire in_item_t               item,
  output logic                        job_push,
  output job_t                        job,
  output logic [COUNT_WIDTH-1:0]      job_base,
  output logic [COUNT_WIDTH-1:0]      job_units
);

  logic                   chk_r, expl_r;
  logic [15:0]            held_r, held_nxt;
  logic                   pend_r, pend_nxt;
  logic                   stop_r, stop_nxt;
  logic [COUNT_WIDTH-1:0] bytes_r, bytes_nxt;
  logic [COUNT_WIDTH-1:0] units_r, units_nxt;

  logic [15:0] c;
  logic        last;
  logic [20:0] cp;
  logic [1:0]  units;
  logic        hold;
  job_t        j;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r  <= 1'b1;
      expl_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_VALIDITY:  chk_r  <= cfg_data[0];
        REG_EXPLICIT_LENGTH: expl_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    c     = item.code_unit;
    last  = item.last_unit;
    cp    = SUPP_BASE + {1'b0, held_r[9:0], c[9:0]};
    units = 2'd0;
    hold  = 1'b0;
    j     = '0;
    j.st  = ST_DATA;
    if (pend_r) begin
      if (chk_r && (c[15:10] != 6'b110111)) begin
        j.st = ST_INVALID;
      end else if (!chk_r && !expl_r && (c == 16'h0000)) begin
        j.st = ST_INVALID;
      end else if (chk_r && (cp[15:1] == 15'h7FFF)) begin
        j.st = ST_INVALID;
      end else begin
        j.bytes[0] = {5'b11110, cp[20:18]};
        j.bytes[1] = {2'b10, cp[17:12]};
        j.bytes[2] = {2'b10, cp[11:6]};
        j.bytes[3] = {2'b10, cp[5:0]};
        j.nb       = 3'd4;
        units      = 2'd2;
      end
    end else if (c[15:7] == 9'd0) begin
      j.bytes[0] = c[7:0];
      j.nb       = 3'd1;
      if (!expl_r && (c == 16'h0000)) begin
        j.st = ST_FINISHED;
      end else begin
        units = 2'd1;
      end
    end else if (c[15:11] == 5'd0) begin
      j.bytes[0] = {3'b110, c[10:6]};
      j.bytes[1] = {2'b10, c[5:0]};
      j.nb       = 3'd2;
      units      = 2'd1;
    end else if (c[15:11] != 5'b11011) begin
      if (chk_r && (((c >= NONCHAR_LO) && (c <= NONCHAR_HI)) || (c[15:1] == 15'h7FFF))) begin
        j.st = ST_INVALID;
      end else begin
        j.bytes[0] = {4'b1110, c[15:12]};
        j.bytes[1] = {2'b10, c[11:6]};
        j.bytes[2] = {2'b10, c[5:0]};
        j.nb       = 3'd3;
        units      = 2'd1;
      end
    end else if (!chk_r || !c[10]) begin
      if (expl_r && last) begin
        j.st = ST_TRUNCATED;
      end else begin
        hold = 1'b1;
      end
    end else begin
      j.st = ST_INVALID;
    end
  end

  always_comb begin
    held_nxt  = held_r;
    pend_nxt  = pend_r;
    stop_nxt  = stop_r;
    bytes_nxt = bytes_r;
    units_nxt = units_r;
    job_push  = 1'b0;
    if (accept && !stop_r) begin
      if (hold) begin
        held_nxt = c;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt  = 1'b0;
        job_push  = 1'b1;
        bytes_nxt = bytes_r + COUNT_WIDTH'(j.nb);
        units_nxt = units_r + COUNT_WIDTH'(units);
        if ((j.st != ST_DATA) || (expl_r && last)) begin
          stop_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      stop_r  <= 1'b0;
      bytes_r <= '0;
      units_r <= '0;
    end else begin
      pend_r  <= pend_nxt;
      stop_r  <= stop_nxt;
      bytes_r <= bytes_nxt;
      units_r <= units_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  assign job       = j;
  assign job_base  = bytes_r;
  assign job_units = units_nxt;

endmodule
`default_nettype wire

// ----- sv/u16u8_jobq.sv -----
// small queue of encoded jobs between front and back end
`default_nettype none
module u16u8_jobq import u16u8_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire job_t                   push_job,
  input  wire logic [COUNT_WIDTH-1:0] push_base,
  input  wire logic [COUNT_WIDTH-1:0] push_units,
  output logic                        full,
  input  wire logic                   pop,
  output logic                        empty,
  output job_t                        head_job,
  output logic [COUNT_WIDTH-1:0]      head_base,
  output logic [COUNT_WIDTH-1:0]      head_units
);

  job_t                   job_r   [JOBQ_DEPTH];
  logic [COUNT_WIDTH-1:0] base_r  [JOBQ_DEPTH];
  logic [COUNT_WIDTH-1:0] units_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [JOBQ_CW-1:0]     cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign full    = (cnt_r == JOBQ_CW'(JOBQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      job_r[wr_r]   <= push_job;
      base_r[wr_r]  <= push_base;
      units_r[wr_r] <= push_units;
    end
  end

  assign head_job   = job_r[rd_r];
  assign head_base  = base_r[rd_r];
  assign head_units = units_r[rd_r];

endmodule
`default_nettype wire

// ----- sv/u16u8_back.sv -----
// back end: walks each job and hands out one result beat per cycle while take is high
`default_nettype none
module u16u8_back import u16u8_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   job_valid,
  input  wire job_t                   job,
  input  wire logic [COUNT_WIDTH-1:0] job_base,
  input  wire logic [COUNT_WIDTH-1:0] job_units,
  output logic                        job_done,
  input  wire logic                   take,
  output out_item_t                   result
);

  logic [1:0]             idx_r, idx_nxt;
  logic [2:0]             n_res;
  logic                   is_data, is_last;
  logic [COUNT_WIDTH-1:0] bw;
  logic [63:0]            bw_ext, uc_ext;

  assign n_res   = job.nb + {2'b00, (job.st != ST_DATA)};
  assign is_data = ({1'b0, idx_r} < job.nb);
  assign is_last = ({1'b0, idx_r} == (n_res - 3'd1));
  assign bw      = is_data ? job_base + COUNT_WIDTH'({idx_r} + 3'd1)
                           : job_base + COUNT_WIDTH'(job.nb);
  assign bw_ext  = 64'(bw);
  assign uc_ext  = 64'(job_units);

  always_comb begin
    result.out_byte       = is_data ? job.bytes[idx_r] : 8'h00;
    result.status         = is_data ? ST_DATA : job.st;
    result.last_of_run    = is_last;
    result.bytes_written  = bw_ext[31:0];
    result.units_consumed = uc_ext[31:0];
  end

  assign job_done = job_valid && take && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (job_valid && take) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- tb/u16u8_stream_checker.sv -----
// stream checker for the utf-16 to utf-8 transcoder: predicts every result beat and compares
module u16u8_stream_checker import u16u8_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire reg_index_t            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  push,
  input  wire logic                  full,
  input  wire in_item_t              in_item,
  input  wire logic                  pop,
  input  wire logic                  empty,
  input  wire out_item_t             out_item,
  output int                         fail_count,
  output int                         beats_checked,
  output int                         beats_due
);
  timeunit 1ns;
  timeprecision 1ps;

  bit          chk_on;
  bit          len_on;
  bit          pair_open;
  bit          halted;
  logic [15:0] hi_unit;
  logic [31:0] byte_count;
  logic [31:0] unit_count;
  out_item_t   due_beats[$];

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t mismatch on %s: expected %h, got %h", $time, fname, want, got);
    end
  endfunction

  task automatic transcode_unit(input logic [15:0] cu, input logic lu);
    logic [3:0][7:0] enc;
    logic [20:0]     cp;
    int              nb;
    int              adv;
    int              k;
    status_t         st;
    nb  = 0;
    adv = 0;
    st  = ST_DATA;
    enc = '0;
    if (halted) return;
    if (pair_open) begin
      pair_open = 1'b0;
      cp = 21'h10000 + {1'b0, hi_unit[9:0], cu[9:0]};
      if (chk_on && !(cu >= 16'hDC00 && cu <= 16'hDFFF)) begin
        st = ST_INVALID;
      end else if (!chk_on && !len_on && cu == 16'h0000) begin
        st = ST_INVALID;
      end else if (chk_on && cp[15:1] == 15'h7FFF) begin
        st = ST_INVALID;
      end else begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
        nb  = 4;
        adv = 2;
      end
    end else if (cu < 16'h0080) begin
      enc[0] = cu[7:0];
      nb = 1;
      if (!len_on && cu == 16'h0000) st = ST_FINISHED;
      else adv = 1;
    end else if (cu < 16'h0800) begin
      enc[0] = {3'b110, cu[10:6]};
      enc[1] = {2'b10, cu[5:0]};
      nb  = 2;
      adv = 1;
    end else if (cu < 16'hD800 || cu > 16'hDFFF) begin
      if (chk_on && ((cu >= NONCHAR_LO && cu <= NONCHAR_HI) || cu[15:1] == 15'h7FFF)) begin
        st = ST_INVALID;
      end else begin
        enc[0] = {4'b1110, cu[15:12]};
        enc[1] = {2'b10, cu[11:6]};
        enc[2] = {2'b10, cu[5:0]};
        nb  = 3;
        adv = 1;
      end
    end else if (!chk_on || cu < 16'hDC00) begin
      if (len_on && lu) begin
        st = ST_TRUNCATED;
      end else begin
        hi_unit   = cu;
        pair_open = 1'b1;
        return;
      end
    end else begin
      st = ST_INVALID;
    end

    unit_count = unit_count + adv;
    for (k = 0; k < nb; k++) begin
      byte_count = byte_count + 1;
      due_beats.push_back('{out_byte: enc[k], status: ST_DATA,
                            last_of_run: (k == nb - 1 && st == ST_DATA),
                            bytes_written: byte_count, units_consumed: unit_count});
    end
    if (st != ST_DATA) begin
      due_beats.push_back('{out_byte: 8'h00, status: st, last_of_run: 1'b1,
                            bytes_written: byte_count, units_consumed: unit_count});
      halted = 1'b1;
    end else if (len_on && lu) begin
      halted = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      chk_on     = 1'b1;
      len_on     = 1'b1;
      pair_open  = 1'b0;
      halted     = 1'b0;
      hi_unit    = '0;
      byte_count = '0;
      unit_count = '0;
      due_beats.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CHECK_VALIDITY) chk_on = cfg_data[0];
        else len_on = cfg_data[0];
      end
      // results are always older than a unit taken on the same edge
      if (pop && !empty) begin
        beats_checked++;
        if (due_beats.size() == 0) begin
          fail_count++;
          $display("%0t unexpected beat: expected nothing, got %h", $time, out_item);
        end else begin
          want = due_beats.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_item.out_byte));
          check_field("status", 32'(want.status), 32'(out_item.status));
          check_field("last_of_run", 32'(want.last_of_run), 32'(out_item.last_of_run));
          check_field("bytes_written", want.bytes_written, out_item.bytes_written);
          check_field("units_consumed", want.units_consumed, out_item.units_consumed);
        end
      end
      if (push && !full) transcode_unit(in_item.code_unit, in_item.last_unit);
    end
    beats_due = due_beats.size();
  end

endmodule

// ----- tb/tb_utf16_to_utf8_transcoder.sv -----
// testbench top for the utf-16 to utf-8 transcoder: stimulus, idling and verdict
module tb_utf16_to_utf8_transcoder;
  import u16u8_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD    = 6;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_UNITS    = 42;
  localparam logic [15:0] UNIT_A = 16'h0041;

  typedef enum int {END_NUL, END_LAST, END_TRUNC, END_BAD} run_end_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  reg_index_t            cfg_index = REG_CHECK_VALIDITY;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  push      = 1'b0;
  logic                  full;
  in_item_t              in_item   = '0;
  logic                  pop       = 1'b0;
  logic                  empty;
  out_item_t             out_item;

  int fail_count;
  int beats_checked;
  int beats_due;
  int units_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int holds_asked;
  int holds_done;
  int hold_left;
  int quiet_cycles;

  utf16_to_utf8_transcoder uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .push, .full, .in_item, .pop, .empty, .out_item
  );

  u16u8_stream_checker checker_i (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .push, .full, .in_item, .pop, .empty, .out_item,
    .fail_count, .beats_checked, .beats_due
  );

  always #(HALF_PERIOD) clk = ~clk;

  // receiver: random idling plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else if (holds_done != holds_asked) begin
      pop <= 1'b0;
      hold_left  = HOLD_CYCLES;
      holds_done = holds_done + 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_unit(input logic [15:0] cu, input logic lu);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= '{code_unit: cu, last_unit: lu};
    do @(posedge clk); while (full);
    @(negedge clk);
    units_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(input logic chk, input logic by_len);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHECK_VALIDITY;
    cfg_data  <= chk;
    @(negedge clk);
    cfg_index <= REG_EXPLICIT_LENGTH;
    cfg_data  <= by_len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_bmp(input bit avoid_nul);
    logic [15:0] cu;
    int          roll;
    do begin
      roll = $urandom_range(99);
      if (roll < 30) cu = 16'($urandom_range(16'h007F, 16'h0000));
      else if (roll < 55) cu = 16'($urandom_range(16'h07FF, 16'h0080));
      else cu = 16'($urandom_range(16'hFFFF, 16'h0800));
    end while ((avoid_nul && cu == 16'h0000) || (cu >= 16'hD800 && cu <= 16'hDFFF) ||
               (cu >= NONCHAR_LO && cu <= NONCHAR_HI) || cu[15:1] == 15'h7FFF);
    return cu;
  endfunction

  task automatic run_phase(input bit chk, input bit by_len, input bit squeeze);
    int          i;
    int          roll;
    logic [15:0] cu;
    logic [15:0] hs;
    logic [15:0] ls;
    logic        lu;
    settle();
    configure(chk, by_len);
    if (squeeze) holds_asked++;
    for (i = 0; i < PHASE_UNITS; i++) begin
      lu   = by_len ? 1'b0 : 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (chk && roll < 25) begin
        hs = 16'($urandom_range(16'hDBFF, 16'hD800));
        do ls = 16'($urandom_range(16'hDFFF, 16'hDC00));
        while (hs[5:0] == 6'h3F && ls[9:1] == 9'h1FF);
        send_unit(hs, lu);
        send_unit(ls, lu);
      end else if (chk) begin
        send_unit(pick_bmp(!by_len), lu);
      end else begin
        if (roll < 35) cu = 16'($urandom_range(16'hDFFF, 16'hD800));
        else cu = 16'($urandom);
        while (!by_len && cu == 16'h0000) cu = 16'($urandom);
        send_unit(cu, lu);
      end
    end
    // closes any pair left open
    if (!chk) send_unit(UNIT_A, 1'b0);
  endtask

  initial begin
    run_end_t    finale;
    int          i;
    int          roll;
    logic        chk;
    logic        by_len;
    logic [15:0] hs;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 34;
    recv_idle_pct = 58;
    configure(1'b1, 1'b1);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFD, 1'b0);
    send_unit(16'hFDCF, 1'b0);
    send_unit(16'hFDF0, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFD, 1'b0);
    send_unit(16'hDBFE, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    settle();
    configure(1'b0, 1'b1);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hFFFE, 1'b0);
    send_unit(16'hFDD0, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(UNIT_A, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    // mode switch with a pair half done
    settle();
    configure(1'b1, 1'b1);
    send_unit(16'hDFFF, 1'b0);

    run_phase(1'b1, 1'b1, 1'b0);
    send_idle_pct = 58;
    recv_idle_pct = 34;
    run_phase(1'b0, 1'b1, 1'b0);
    run_phase(1'b1, 1'b0, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1'b0, 1'b0, 1'b1);

    settle();
    finale = run_end_t'($urandom_range(3));
    chk    = 1'($urandom_range(1));
    by_len = 1'($urandom_range(1));
    case (finale)
      END_NUL: begin
        configure(chk, 1'b0);
        for (i = 0; i < 5; i++) send_unit(pick_bmp(1'b1), 1'($urandom_range(1)));
        send_unit(16'h0000, 1'($urandom_range(1)));
      end
      END_LAST: begin
        configure(chk, 1'b1);
        for (i = 0; i < 5; i++) send_unit(pick_bmp(1'b0), 1'b0);
        send_unit(pick_bmp(1'b0), 1'b1);
      end
      END_TRUNC: begin
        configure(chk, 1'b1);
        for (i = 0; i < 4; i++) send_unit(pick_bmp(1'b0), 1'b0);
        if (chk) hs = 16'($urandom_range(16'hDBFF, 16'hD800));
        else hs = 16'($urandom_range(16'hDFFF, 16'hD800));
        send_unit(hs, 1'b1);
      end
      default: begin
        roll = $urandom_range(99);
        if (roll < 85) configure(1'b1, by_len);
        else configure(1'b0, 1'b0);
        for (i = 0; i < 3; i++) send_unit(pick_bmp(1'b1), 1'b0);
        if (roll < 20) begin
          send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), 1'b0);
        end else if (roll < 40) begin
          send_unit(16'($urandom_range(NONCHAR_HI, NONCHAR_LO)), 1'b0);
        end else if (roll < 55) begin
          send_unit(16'hFFFE | 16'($urandom_range(1)), 1'b0);
        end else if (roll < 70) begin
          send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), 1'b0);
          send_unit(pick_bmp(1'b1), 1'b0);
        end else if (roll < 85) begin
          send_unit(16'hD83F | 16'($urandom_range(15) << 6), 1'b0);
          send_unit(16'hDFFE | 16'($urandom_range(1)), 1'b0);
        end else begin
          send_unit(16'($urandom_range(16'hDFFF, 16'hD800)), 1'b0);
          send_unit(16'h0000, 1'b0);
        end
      end
    endcase
    // the block must now ignore everything
    for (i = 0; i < 6; i++) send_unit(16'($urandom), 1'($urandom_range(1)));

    push <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("run covered %0d code units and %0d result beats over all four mode settings",
             units_sent, beats_checked);
    $display("stream ended by %s, then units sent after the stop were dropped",
             finale.name());
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
